### hw/rtl/gwf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gwf_pkg;

  // Sizing
  localparam int MAX_PATTERN_BYTES = 24;
  localparam int MAX_LINE_BYTES    = 4096;
  localparam int OFS_W             = $clog2(MAX_LINE_BYTES);
  localparam int PAT_BITS          = 192;
  localparam int MC_W              = $clog2(MAX_PATTERN_BYTES + 1);

  // Register map (index = paddr / 8)
  localparam logic [2:0] REG_PAT_LOW  = 3'd0;
  localparam logic [2:0] REG_PAT_MID  = 3'd1;
  localparam logic [2:0] REG_PAT_HIGH = 3'd2;
  localparam logic [2:0] REG_PAT_LEN  = 3'd3;
  localparam logic [2:0] REG_CN_MODE  = 3'd4;
  localparam logic [2:0] REG_MAX_SPAN = 3'd5;
  localparam logic [2:0] REG_PAT_ID   = 3'd6;

  localparam logic [4:0] PAT_LEN_RESET  = 5'd1;
  localparam logic [7:0] MAX_SPAN_RESET = 8'd40;
  localparam logic [7:0] CASE_BIT       = 8'd32;

  typedef struct packed {
    logic [PAT_BITS-1:0] pattern;
    logic [4:0]          pat_len;
    logic                cn_mode;
    logic [7:0]          max_span;
    logic [9:0]          pat_id;
  } cfg_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] line;
    logic [11:0] first;
    logic [11:0] last;
  } match_t;

  function automatic logic [7:0] pat_byte(input logic [PAT_BITS-1:0] pat,
                                          input logic [5:0] idx);
    logic [7:0] b;
    b = 8'd0;
    if (32'(idx) < MAX_PATTERN_BYTES) begin
      b = pat[8*idx +: 8];
    end
    return b;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic eq_nocase(input logic [7:0] t, input logic [7:0] p);
    return (t == p) ||
           (is_letter(t) && is_letter(p) && ((t | CASE_BIT) == (p | CASE_BIT)));
  endfunction

endpackage

`default_nettype wire

### hw/rtl/gapped_word_filter_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Gapped word filter. Bytes of text lines arrive one request at a time
// (kind = 0 for a byte, kind = 1 closes the line) and are matched against one
// configured word as an in-order subsequence: other bytes may sit between the
// matched ones. With cn_mode = 0 each pattern byte is compared with one
// text byte, ASCII letters without regard to case. With cn_mode = 1 a
// 3-byte pattern unit is compared with the 3-byte window ending at each byte,
// and the two windows overlapping a matched unit are skipped. A full match
// yields one result request (pattern id, line index, first and last byte
// offset) and matching restarts; a match whose span exceeds max_span stops the
// search until end of line. Bytes past offset 4095 of a line are ignored.
// Throughput is one request per cycle. A request is first held in the input
// register; the match state update then loads the result register from it.
// While a result waits on out_ready the held request waits too, and the input
// stalls once the input register is full. Configuration is written over the
// APB port at byte address 8*index (64-bit data); writes are legal only while
// the block is idle and abort any partial match.

module gapped_word_filter_unit import gwf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // input requests
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        kind,
  input  wire logic [7:0]  text_byte,
  // result requests
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [9:0]       match_pattern,
  output logic [15:0]      match_line,
  output logic [11:0]      match_first,
  output logic [11:0]      match_last,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  cfg_t       cfg;
  logic       cfg_wr;
  match_t     res;

  // input register
  logic       s1_valid;
  logic       s1_kind;
  logic [7:0] s1_byte;
  logic       fire;

  assign pready = 1'b1;

  // the held request is processed as soon as the result slot is free or
  // being emptied this cycle
  assign fire     = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || fire;

  gwf_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg),
    .cfg_wr  (cfg_wr)
  );

  gwf_match_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .step      (fire),
    .kind      (s1_kind),
    .text_byte (s1_byte),
    .cfg       (cfg),
    .cfg_wr    (cfg_wr),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind <= kind;
      s1_byte <= text_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= res.hit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.hit) begin
      match_pattern <= cfg.pat_id;
      match_line    <= res.line;
      match_first   <= res.first;
      match_last    <= res.last;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/gwf_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module gwf_cfg_regs import gwf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output cfg_t             cfg,
  output logic             cfg_wr
);

  logic       wr_en;
  logic [2:0] idx;

  assign idx   = paddr[5:3];
  assign wr_en = psel && penable && pwrite;
  // any real register write aborts a partial match
  assign cfg_wr = wr_en && (idx <= REG_PAT_ID);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern  <= '0;
      cfg.pat_len  <= PAT_LEN_RESET;
      cfg.cn_mode  <= 1'b0;
      cfg.max_span <= MAX_SPAN_RESET;
      cfg.pat_id   <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_PAT_LOW:  cfg.pattern[63:0]    <= pwdata;
        REG_PAT_MID:  cfg.pattern[127:64]  <= pwdata;
        REG_PAT_HIGH: cfg.pattern[191:128] <= pwdata;
        REG_PAT_LEN:  cfg.pat_len  <= pwdata[4:0];
        REG_CN_MODE:  cfg.cn_mode  <= pwdata[0];
        REG_MAX_SPAN: cfg.max_span <= pwdata[7:0];
        REG_PAT_ID:   cfg.pat_id   <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PAT_LOW:  prdata = cfg.pattern[63:0];
      REG_PAT_MID:  prdata = cfg.pattern[127:64];
      REG_PAT_HIGH: prdata = cfg.pattern[191:128];
      REG_PAT_LEN:  prdata = 64'(cfg.pat_len);
      REG_CN_MODE:  prdata = 64'(cfg.cn_mode);
      REG_MAX_SPAN: prdata = 64'(cfg.max_span);
      REG_PAT_ID:   prdata = 64'(cfg.pat_id);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/gwf_match_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module gwf_match_engine import gwf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic       kind,
  input  wire logic [7:0] text_byte,
  input  wire cfg_t       cfg,
  input  wire logic       cfg_wr,
  output match_t          res
);

  logic [MC_W-1:0]  matched_count, matched_count_next;
  logic [OFS_W-1:0] start_offset, start_offset_next;
  logic [OFS_W:0]   byte_offset, byte_offset_next;
  logic [15:0]      line_counter, line_counter_next;
  logic             line_stopped, line_stopped_next;
  logic [7:0]       prev1, prev1_next, prev2, prev2_next;
  logic [1:0]       skip_windows, skip_windows_next;

  logic [OFS_W-1:0] j, st, span_dist;
  logic             len_ok, in_line, hit_en, hit_cn, span_bad, at_two;
  logic             whole_units;
  logic [5:0]       mc6, mc_inc;

  // lengths that are a whole number of 3-byte units
  always_comb begin
    unique case (cfg.pat_len)
      5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21, 5'd24: whole_units = 1'b1;
      default: whole_units = 1'b0;
    endcase
  end

  assign j       = byte_offset[OFS_W-1:0];
  assign in_line = !byte_offset[OFS_W];
  assign mc6     = 6'(matched_count);
  assign at_two  = (j[OFS_W-1:1] != '0);
  assign len_ok  = (cfg.pat_len != '0) && (32'(cfg.pat_len) <= MAX_PATTERN_BYTES) &&
                   (!cfg.cn_mode || whole_units);

  assign hit_en = eq_nocase(text_byte, pat_byte(cfg.pattern, mc6));
  assign hit_cn = (prev2 == pat_byte(cfg.pattern, mc6)) &&
                  (prev1 == pat_byte(cfg.pattern, mc6 + 6'd1)) &&
                  (text_byte == pat_byte(cfg.pattern, mc6 + 6'd2)) && at_two;

  // start of a new match: the byte itself, or the first byte of the unit
  always_comb begin
    if (matched_count != '0) begin
      st = start_offset;
    end else if (cfg.cn_mode) begin
      st = j - OFS_W'(2);
    end else begin
      st = j;
    end
  end

  assign span_dist = j - st;
  assign span_bad  = 32'(span_dist) > 32'(cfg.max_span);
  assign mc_inc    = mc6 + (cfg.cn_mode ? 6'd3 : 6'd1);

  always_comb begin
    matched_count_next = matched_count;
    start_offset_next  = start_offset;
    byte_offset_next   = byte_offset;
    line_counter_next  = line_counter;
    line_stopped_next  = line_stopped;
    prev1_next         = prev1;
    prev2_next         = prev2;
    skip_windows_next  = skip_windows;
    res.hit            = 1'b0;
    res.line           = line_counter;
    res.first          = 12'(st);
    res.last           = 12'(j);

    if (step) begin
      if (kind) begin
        line_counter_next  = line_counter + 16'd1;
        matched_count_next = '0;
        start_offset_next  = '0;
        byte_offset_next   = '0;
        line_stopped_next  = 1'b0;
        skip_windows_next  = '0;
        prev1_next         = '0;
        prev2_next         = '0;
      end else if (in_line) begin
        byte_offset_next = byte_offset + {{OFS_W{1'b0}}, 1'b1};
        prev1_next       = text_byte;
        prev2_next       = prev1;
        if (!line_stopped && len_ok) begin
          if (cfg.cn_mode && skip_windows != '0) begin
            skip_windows_next = skip_windows - 2'd1;
          end else if (cfg.cn_mode ? hit_cn : hit_en) begin
            start_offset_next = st;
            if (cfg.cn_mode) begin
              skip_windows_next = 2'd2;
            end
            if (span_bad) begin
              line_stopped_next = 1'b1;
              // unit mode keeps the advanced count, byte mode does not
              if (cfg.cn_mode) begin
                matched_count_next = MC_W'(mc_inc);
              end
            end else if (mc_inc >= 6'(cfg.pat_len)) begin
              matched_count_next = '0;
              res.hit            = 1'b1;
            end else begin
              matched_count_next = MC_W'(mc_inc);
            end
          end
        end
      end
    end else if (cfg_wr) begin
      matched_count_next = '0;
      skip_windows_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      matched_count <= '0;
      start_offset  <= '0;
      byte_offset   <= '0;
      line_counter  <= '0;
      line_stopped  <= 1'b0;
      prev1         <= '0;
      prev2         <= '0;
      skip_windows  <= '0;
    end else begin
      matched_count <= matched_count_next;
      start_offset  <= start_offset_next;
      byte_offset   <= byte_offset_next;
      line_counter  <= line_counter_next;
      line_stopped  <= line_stopped_next;
      prev1         <= prev1_next;
      prev2         <= prev2_next;
      skip_windows  <= skip_windows_next;
    end
  end

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import gwf_pkg::*;

  // input request kinds
  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  // register index past the end of the map; a write there must change nothing
  localparam logic [2:0] REG_UNMAPPED = 3'd7;

  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 240;
  localparam int SETTLE_TICKS = 4;   // covers the input and result registers

  typedef struct packed {
    logic [9:0]  pat_id;
    logic [15:0] line_idx;
    logic [11:0] first_ofs;
    logic [11:0] last_ofs;
  } match_result_t;

  typedef enum logic [1:0] {ROW_TEXT, ROW_EOL, ROW_WRITE} row_op_e;

  // one line of the directed stimulus; typed rows carry their own expected result
  typedef struct packed {
    row_op_e       op;
    logic [2:0]    reg_idx;
    logic [63:0]   value;
    logic [7:0]    text;
    logic          typed;
    match_result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        kind;
  logic [7:0]  text_byte;
  logic        out_valid;
  logic        out_ready;
  logic [9:0]  match_pattern;
  logic [15:0] match_line;
  logic [11:0] match_first;
  logic [11:0] match_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  gapped_word_filter_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .text_byte     (text_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .match_pattern (match_pattern),
    .match_line    (match_line),
    .match_first   (match_first),
    .match_last    (match_last),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the block: configuration copy plus the per-line match state.
  // ---------------------------------------------------------------------------
  logic [191:0] word_bits;
  logic [4:0]   word_len;
  logic         cn_mode;
  logic [7:0]   span_limit;
  logic [9:0]   word_id;

  logic [4:0]   matched;      // pattern bytes matched so far
  logic [11:0]  start_ofs;    // offset of first matched byte
  logic [12:0]  byte_ofs;     // next byte offset in the line
  logic [15:0]  line_no;
  logic         stopped;      // span blown, idle until end of line
  logic [7:0]   recent [2];   // [0] previous byte, [1] the one before
  logic [1:0]   skips;        // unit windows still to skip

  match_result_t pending_matches [$];

  int send_idle_pct;
  int stall_pct;
  int failures;
  int requests_sent;
  int lines_sent;
  int results_checked;

  function automatic logic [7:0] word_byte(input int unsigned idx);
    if (idx >= MAX_PATTERN_BYTES) return 8'h00;
    return word_bits[8*idx +: 8];
  endfunction

  // equal, or the same ASCII letter in either case
  function automatic bit same_letter(input logic [7:0] t, input logic [7:0] p);
    logic [7:0] lt, lp;
    lt = t | 8'h20;
    lp = p | 8'h20;
    return (t == p) || (lt == lp && lt >= 8'h61 && lt <= 8'h7A);
  endfunction

  function automatic void clear_line_state();
    matched   = '0;
    start_ofs = '0;
    byte_ofs  = '0;
    stopped   = 1'b0;
    skips     = '0;
    recent[0] = '0;
    recent[1] = '0;
  endfunction

  // register write as the block sees it; mapped writes abort a partial match
  function automatic void apply_write(input logic [2:0] idx, input logic [63:0] value);
    case (idx)
      REG_PAT_LOW:  word_bits[63:0]    = value;
      REG_PAT_MID:  word_bits[127:64]  = value;
      REG_PAT_HIGH: word_bits[191:128] = value;
      REG_PAT_LEN:  word_len           = value[4:0];
      REG_CN_MODE:  cn_mode            = value[0];
      REG_MAX_SPAN: span_limit         = value[7:0];
      REG_PAT_ID:   word_id            = value[9:0];
      default: return;
    endcase
    matched = '0;
    skips   = '0;
  endfunction

  // Advance the shadow by one input request; returns 1 with the match result
  // when the request completes the word.
  function automatic bit match_step(input logic k, input logic [7:0] b,
                                    output match_result_t r);
    int unsigned j, mc;
    logic [7:0]  p1, p2;
    bit          usable;
    r = '0;
    if (k == KIND_EOL) begin
      line_no++;
      clear_line_state();
      return 0;
    end
    if (byte_ofs >= MAX_LINE_BYTES) return 0;
    j = byte_ofs;
    byte_ofs = 13'(j + 1);
    p1 = recent[0];
    p2 = recent[1];
    recent[1] = p1;
    recent[0] = b;
    usable = word_len >= 1 && word_len <= MAX_PATTERN_BYTES &&
             (!cn_mode || word_len % 3 == 0);
    if (stopped || !usable) return 0;
    mc = matched;
    if (!cn_mode) begin
      if (!same_letter(b, word_byte(mc))) return 0;
      if (mc == 0) start_ofs = 12'(j);
      if (j - start_ofs > span_limit) begin
        stopped = 1'b1;
        return 0;
      end
      mc++;
    end else begin
      if (skips > 0) begin
        skips--;
        return 0;
      end
      if (j < 2) return 0;   // window would start before the line
      if (p2 != word_byte(mc) || p1 != word_byte(mc + 1) || b != word_byte(mc + 2))
        return 0;
      if (mc == 0) start_ofs = 12'(j - 2);
      mc += 3;
      skips = 2'd2;          // the two windows overlapping this unit
      if (j - start_ofs > span_limit) begin
        matched = 5'(mc);
        stopped = 1'b1;
        return 0;
      end
    end
    if (mc >= word_len) begin
      matched     = '0;
      r.pat_id    = word_id;
      r.line_idx  = line_no;
      r.first_ofs = start_ofs;
      r.last_ofs  = 12'(j);
      return 1;
    end
    matched = 5'(mc);
    return 0;
  endfunction

  function automatic void note_failure(input string what);
    failures++;
    if (failures <= 10) $display("mismatch: %s", what);
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table helpers
  // ---------------------------------------------------------------------------
  function automatic stim_row_t row_text(input logic [7:0] b);
    stim_row_t r;
    r = '0;
    r.op = ROW_TEXT;
    r.text = b;
    return r;
  endfunction

  function automatic stim_row_t row_hit(input logic [7:0] b, input logic [9:0] id,
                                        input logic [15:0] ln, input logic [11:0] f,
                                        input logic [11:0] l);
    stim_row_t r;
    r = row_text(b);
    r.typed = 1'b1;
    r.want = '{pat_id: id, line_idx: ln, first_ofs: f, last_ofs: l};
    return r;
  endfunction

  function automatic stim_row_t row_eol();
    stim_row_t r;
    r = '0;
    r.op = ROW_EOL;
    r.text = 8'hA5;   // ignored by the block
    return r;
  endfunction

  function automatic stim_row_t row_write(input logic [2:0] idx, input logic [63:0] v);
    stim_row_t r;
    r = '0;
    r.op = ROW_WRITE;
    r.reg_idx = idx;
    r.value = v;
    return r;
  endfunction

  // random byte, half the time one of the word's own bytes
  function automatic logic [7:0] filler_byte();
    if ($urandom_range(1)) return word_byte($urandom_range(MAX_PATTERN_BYTES - 1));
    return 8'($urandom_range(255));
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: optional idle gap, then hold valid until accepted. Valid is
  // left high after acceptance so back-to-back requests never toggle it.
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic k, input logic [7:0] b, input logic typed,
                              input match_result_t want);
    match_result_t got;
    bit hit;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    text_byte <= b;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
    if (k == KIND_EOL) lines_sent++;
    hit = match_step(k, b, got);
    if (typed) pending_matches.push_back(want);
    else if (hit) pending_matches.push_back(got);
  endtask

  // drop valid and let every outstanding result drain, plus pipeline slack
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // APB write: setup phase, access phase, then psel drops and the bus idles before returning
  task automatic write_register(input logic [2:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    apply_write(idx, value);
    @(posedge clk);
  endtask

  // Pick and program a configuration for one random phase. The first four
  // phases pin the extremes; later ones are random, sometimes with an
  // unusable length. Narrow registers get junk in their unused data bits.
  task automatic phase_setup(input int p);
    logic [191:0] word;
    logic [63:0]  noise;
    logic [4:0]   len;
    logic [7:0]   span;
    logic [9:0]   id;
    logic         cn;
    cn   = $urandom_range(1);
    len  = cn ? 5'(3 * $urandom_range(1, 8)) : 5'($urandom_range(1, 24));
    span = ($urandom_range(2) == 0) ? 8'd255 : 8'($urandom_range(4, 120));
    id   = 10'($urandom_range(1023));
    case (p)
      0: begin cn = 1'b0; len = 5'd24; span = 8'd255; id = 10'd1023; end
      1: begin cn = 1'b1; len = 5'd24; span = 8'd255; id = 10'd0; end
      2: begin cn = 1'b0; len = 5'd1; span = 8'd0; end
      3: begin cn = 1'b1; len = 5'd3; span = 8'd2; end
      default: if ($urandom_range(5) == 0) begin
        case ($urandom_range(2))
          0: len = 5'd0;
          1: len = 5'($urandom_range(25, 31));
          default: begin
            cn  = 1'b1;
            len = 5'(3 * $urandom_range(0, 7) + $urandom_range(1, 2));
          end
        endcase
      end
    endcase
    // English words get plenty of letters so case folding is exercised
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      if (!cn && $urandom_range(1))
        word[8*i +: 8] = 8'($urandom_range(25)) + ($urandom_range(1) ? 8'h41 : 8'h61);
      else
        word[8*i +: 8] = 8'($urandom_range(255));
    end
    wait_idle();
    noise = {$urandom, $urandom};
    write_register(REG_PAT_LOW, word[63:0]);
    write_register(REG_PAT_MID, word[127:64]);
    write_register(REG_PAT_HIGH, word[191:128]);
    write_register(REG_PAT_LEN, {noise[63:5], len});
    write_register(REG_CN_MODE, {noise[63:1], cn});
    write_register(REG_MAX_SPAN, {noise[63:8], span});
    write_register(REG_PAT_ID, {noise[63:10], id});
  endtask

  // One text line. Most lines carry the word with random gaps (letters in
  // random case); some give up partway, the rest are noise.
  task automatic send_line();
    int unsigned limit, unit_w, gap;
    logic [7:0]  c;
    if ($urandom_range(9) < 3) begin
      repeat ($urandom_range(24)) send_request(KIND_TEXT, filler_byte(), 1'b0, '0);
    end else begin
      unit_w = cn_mode ? 3 : 1;
      limit  = (word_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : word_len;
      repeat ($urandom_range(1, 2)) begin
        for (int i = 0; i < limit; i += unit_w) begin
          if ($urandom_range(15) == 0) break;
          gap = ($urandom_range(7) == 0) ? $urandom_range(12) : $urandom_range(3);
          repeat (gap) send_request(KIND_TEXT, filler_byte(), 1'b0, '0);
          for (int u = 0; u < unit_w; u++) begin
            c = word_byte(i + u);
            if (!cn_mode && (c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A &&
                $urandom_range(1))
              c = c ^ 8'h20;
            send_request(KIND_TEXT, c, 1'b0, '0);
          end
        end
      end
      repeat ($urandom_range(2)) send_request(KIND_TEXT, filler_byte(), 1'b0, '0);
    end
    // now and then hold off until every pending result is out
    if (lines_sent % 16 == 15) wait_idle();
    send_request(KIND_EOL, 8'($urandom_range(255)), 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset, time limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random stalls, every accepted result checked against the
  // oldest pending expectation.
  // ---------------------------------------------------------------------------
  initial begin : result_monitor
    match_result_t seen, want;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        seen = '{pat_id: match_pattern, line_idx: match_line,
                 first_ofs: match_first, last_ofs: match_last};
        results_checked++;
        if (pending_matches.size() == 0) begin
          note_failure($sformatf("unexpected result id %h line %0d first %0d last %0d",
                                 seen.pat_id, seen.line_idx, seen.first_ofs,
                                 seen.last_ofs));
        end else begin
          want = pending_matches.pop_front();
          if (seen.pat_id != want.pat_id || seen.line_idx != want.line_idx ||
              seen.first_ofs != want.first_ofs || seen.last_ofs != want.last_ofs)
            note_failure($sformatf({"expected id %h line %0d first %0d last %0d, ",
                                    "got id %h line %0d first %0d last %0d"},
                                   want.pat_id, want.line_idx, want.first_ofs,
                                   want.last_ofs, seen.pat_id, seen.line_idx,
                                   seen.first_ofs, seen.last_ofs));
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t directed_rows [$];
    logic [7:0] edge_byte;
    int first_req;

    rst       = 1'b1;
    in_valid  = 1'b0;
    kind      = KIND_TEXT;
    text_byte = 8'h00;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    failures        = 0;
    requests_sent   = 0;
    lines_sent      = 0;
    results_checked = 0;

    // shadow starts from the reset configuration
    word_bits  = '0;
    word_len   = PAT_LEN_RESET;
    cn_mode    = 1'b0;
    span_limit = MAX_SPAN_RESET;
    word_id    = '0;
    line_no    = '0;
    clear_line_state();

    // reset word is a single 0x00 byte
    directed_rows.push_back(row_hit(8'h00, 10'd0, 16'd0, 12'd0, 12'd0));
    directed_rows.push_back(row_text(8'h41));
    directed_rows.push_back(row_hit(8'h00, 10'd0, 16'd0, 12'd2, 12'd2));
    directed_rows.push_back(row_eol());
    // word "a@Z": letters fold, but '`' is not '@' even though only bit 5 differs
    directed_rows.push_back(row_write(REG_PAT_LOW, 64'h0000_0000_005A_4061));
    directed_rows.push_back(row_write(REG_PAT_LEN, 64'd3));
    directed_rows.push_back(row_write(REG_MAX_SPAN, 64'd255));
    directed_rows.push_back(row_write(REG_PAT_ID, 64'h3FF));
    directed_rows.push_back(row_text(8'h41));                 // 'A'
    // write past the register map mid-match: must not abort it
    directed_rows.push_back(row_write(REG_UNMAPPED, '1));
    directed_rows.push_back(row_text(8'h60));                 // '`'
    directed_rows.push_back(row_text(8'h40));                 // '@'
    directed_rows.push_back(row_hit(8'h7A, 10'h3FF, 16'd1, 12'd0, 12'd3));
    directed_rows.push_back(row_eol());
    // two 3-byte units back to back; the overlapping windows are skipped
    directed_rows.push_back(row_write(REG_PAT_LOW, 64'h0000_8796_E6AD_B8E4));
    directed_rows.push_back(row_write(REG_PAT_MID, '1));
    directed_rows.push_back(row_write(REG_PAT_HIGH, '1));
    directed_rows.push_back(row_write(REG_PAT_LEN, 64'd6));
    directed_rows.push_back(row_write(REG_CN_MODE, 64'd1));
    directed_rows.push_back(row_text(8'hE4));
    directed_rows.push_back(row_text(8'hB8));
    directed_rows.push_back(row_text(8'hAD));
    directed_rows.push_back(row_text(8'hE6));
    directed_rows.push_back(row_text(8'h96));
    directed_rows.push_back(row_hit(8'h87, 10'h3FF, 16'd2, 12'd0, 12'd5));
    directed_rows.push_back(row_eol());
    // zero span: the second matched byte stops the line
    directed_rows.push_back(row_write(REG_CN_MODE, 64'd0));
    directed_rows.push_back(row_write(REG_PAT_LEN, 64'd2));
    directed_rows.push_back(row_write(REG_MAX_SPAN, 64'd0));
    directed_rows.push_back(row_text(8'hE4));
    directed_rows.push_back(row_text(8'hB8));
    directed_rows.push_back(row_text(8'hE4));
    directed_rows.push_back(row_eol());
    // unusable lengths: zero, above the maximum, not whole units
    directed_rows.push_back(row_write(REG_PAT_LEN, 64'd0));
    directed_rows.push_back(row_text(8'hE4));
    directed_rows.push_back(row_write(REG_PAT_LEN, 64'd31));
    directed_rows.push_back(row_text(8'hE4));
    directed_rows.push_back(row_write(REG_CN_MODE, 64'd1));
    directed_rows.push_back(row_write(REG_PAT_LEN, 64'd4));
    directed_rows.push_back(row_text(8'hE4));
    directed_rows.push_back(row_text(8'hB8));
    directed_rows.push_back(row_text(8'hAD));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      case (directed_rows[i].op)
        ROW_WRITE: begin
          wait_idle();
          write_register(directed_rows[i].reg_idx, directed_rows[i].value);
        end
        ROW_EOL: send_request(KIND_EOL, directed_rows[i].text, 1'b0, '0);
        default: send_request(KIND_TEXT, directed_rows[i].text, directed_rows[i].typed,
                              directed_rows[i].want);
      endcase
    end

    // Random phases; each programs every register (aborting any partial match
    // left from the previous phase) and cycles through the idling mixes.
    for (int p = 0; p < PHASES; p++) begin
      phase_setup(p);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 49; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 49; end
        default: begin send_idle_pct = 24; stall_pct = 24; end
      endcase
      if (p == 2) begin
        // over-long line: the word byte lands on the last two legal offsets
        // and on two offsets past the line limit, which must be ignored
        edge_byte = word_byte(0);
        repeat (MAX_LINE_BYTES - 2) send_request(KIND_TEXT, filler_byte(), 1'b0, '0);
        repeat (4) send_request(KIND_TEXT, edge_byte, 1'b0, '0);
        send_request(KIND_EOL, 8'($urandom_range(255)), 1'b0, '0);
      end
      first_req = requests_sent;
      while (requests_sent - first_req < PHASE_ITEMS) send_line();
    end

    // drain
    in_valid <= 1'b0;
    stall_pct = 0;
    for (int n = 0; n < 1000 && pending_matches.size() != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_matches.size() != 0)
      note_failure($sformatf("%0d expected results never arrived",
                             pending_matches.size()));

    $display("Run covered %0d input requests in %0d lines over %0d config phases.",
             requests_sent, lines_sent, PHASES + 1);
    $display("%0d match results checked, %0d failures.", results_checked, failures);
    if (failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
